/* src/zsbe_pkg.sv */
`timescale 1ns / 1ps

package zsbe_pkg;

  // Input kinds carried on the slave-side tuser bit
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_DATA  = 1'b1;

  localparam logic [7:0] ZLIB_CMF = 8'h78;
  localparam logic [7:0] ZLIB_FLG = 8'h01;

  localparam logic [7:0] BLK_FINAL     = 8'h01;
  localparam logic [7:0] BLK_NOT_FINAL = 8'h00;

  localparam logic [15:0] MAX_BLOCK_BYTES = 16'd65535;
  localparam logic [16:0] ADLER_MOD       = 17'd65521;

  localparam int unsigned MAX_RUN_BYTES = 10;
  localparam int unsigned RUN_IDX_W     = $clog2(MAX_RUN_BYTES + 1);
  localparam int unsigned BLK_HDR_BYTES = 5;
  localparam int unsigned ADLER_BYTES   = 4;

  // One run: the output bytes caused by one accepted item
  typedef struct packed {
    logic [MAX_RUN_BYTES-1:0][7:0] bytes;
    logic [RUN_IDX_W-1:0]          count;
    logic                          done;
  } run_t;

endpackage

/* src/zsbe_core.sv */
`timescale 1ns / 1ps

module zsbe_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                accept_i,
  input  logic                mode_i,
  input  logic [7:0]          data_byte_i,
  output logic                push_o,
  output zsbe_pkg::run_t      run_o
);
  import zsbe_pkg::*;

  logic [31:0] stream_len_q;
  logic [31:0] total_q, total_d;
  logic [15:0] block_q, block_d;
  logic [15:0] low_q, low_d;
  logic [15:0] high_q, high_d;

  logic [16:0] low_sum, high_sum;
  logic [15:0] low_n, high_n;
  logic [15:0] blk_len, blk_nlen;
  logic        blk_final, has_blk, ends_stream;
  logic [RUN_IDX_W-1:0] dpos;
  run_t        run;

  // Adler-32 update: one compare-subtract per sum
  assign low_sum  = {1'b0, low_q} + {9'b0, data_byte_i};
  assign low_n    = (low_sum >= ADLER_MOD) ? 16'(low_sum - ADLER_MOD) : low_sum[15:0];
  assign high_sum = {1'b0, high_q} + {1'b0, low_n};
  assign high_n   = (high_sum >= ADLER_MOD) ? 16'(high_sum - ADLER_MOD) : high_sum[15:0];

  assign blk_final   = (total_q <= {16'b0, MAX_BLOCK_BYTES});
  assign blk_len     = blk_final ? total_q[15:0] : MAX_BLOCK_BYTES;
  assign blk_nlen    = ~blk_len;
  assign has_blk     = (block_q == 16'd0);
  assign ends_stream = (total_q == 32'd1);
  assign dpos        = has_blk ? RUN_IDX_W'(BLK_HDR_BYTES) : '0;

  always_comb begin
    run      = '0;
    total_d  = total_q;
    block_d  = block_q;
    low_d    = low_q;
    high_d   = high_q;
    push_o   = 1'b0;
    if (mode_i == MODE_START) begin
      push_o        = accept_i;
      total_d       = stream_len_q;
      block_d       = '0;
      low_d         = 16'd1;
      high_d        = '0;
      run.bytes[0]  = ZLIB_CMF;
      run.bytes[1]  = ZLIB_FLG;
      if (stream_len_q == 32'd0) begin
        // empty stream: Adler of no data is 00 00 00 01
        run.bytes[5] = 8'h01;
        run.count    = RUN_IDX_W'(2 + ADLER_BYTES);
        run.done     = 1'b1;
      end else begin
        run.count    = RUN_IDX_W'(2);
      end
    end else if (total_q != 32'd0) begin
      push_o = accept_i;
      if (has_blk) begin
        run.bytes[0] = blk_final ? BLK_FINAL : BLK_NOT_FINAL;
        run.bytes[1] = blk_len[7:0];
        run.bytes[2] = blk_len[15:8];
        run.bytes[3] = blk_nlen[7:0];
        run.bytes[4] = blk_nlen[15:8];
      end
      run.bytes[dpos] = data_byte_i;
      low_d   = low_n;
      high_d  = high_n;
      total_d = total_q - 32'd1;
      block_d = (has_blk ? blk_len : block_q) - 16'd1;
      if (ends_stream) begin
        block_d                 = '0;
        run.bytes[dpos + 4'd1]  = high_n[15:8];
        run.bytes[dpos + 4'd2]  = high_n[7:0];
        run.bytes[dpos + 4'd3]  = low_n[15:8];
        run.bytes[dpos + 4'd4]  = low_n[7:0];
        run.count               = dpos + RUN_IDX_W'(1 + ADLER_BYTES);
        run.done                = 1'b1;
      end else begin
        run.count               = dpos + 4'd1;
      end
    end
  end

  assign run_o = run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_len_q <= '0;
      total_q      <= '0;
      block_q      <= '0;
      low_q        <= 16'd1;
      high_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        stream_len_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        total_q <= total_d;
        block_q <= block_d;
        low_q   <= low_d;
        high_q  <= high_d;
      end
    end
  end

`ifndef SYNTHESIS
  a_adler_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, low_q} < ADLER_MOD) && ({1'b0, high_q} < ADLER_MOD))
    else $error("adler sum out of range");
  a_block_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q == 32'd0) |-> (block_q == 16'd0))
    else $error("block count left open after stream end");
`endif

endmodule

/* src/zsbe_fifo.sv */
`timescale 1ns / 1ps

module zsbe_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  zsbe_pkg::run_t run_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output zsbe_pkg::run_t run_o
);
  import zsbe_pkg::*;

  run_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign run_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= run_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("run queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("run queue underflow");
`endif

endmodule

/* src/zsbe_ser.sv */
`timescale 1ns / 1ps

module zsbe_ser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           avail_i,
  input  zsbe_pkg::run_t run_i,
  output logic           load_o,
  output logic           valid_o,
  input  logic           ready_i,
  output logic [7:0]     byte_o,
  output logic           last_o,
  output logic           done_o
);
  import zsbe_pkg::*;

  run_t                 cur_q;
  logic                 valid_q;
  logic [RUN_IDX_W-1:0] idx_q;
  logic                 last_byte;

  assign last_byte = (idx_q == cur_q.count - 4'd1);
  assign load_o    = avail_i && (!valid_q || (ready_i && last_byte));

  assign valid_o = valid_q;
  assign byte_o  = cur_q.bytes[idx_q];
  assign last_o  = last_byte;
  assign done_o  = cur_q.done && last_byte;

  always_ff @(posedge clk_i) begin
    if (load_o) begin
      cur_q <= run_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load_o) begin
        valid_q <= 1'b1;
        idx_q   <= '0;
      end else if (valid_q && ready_i) begin
        if (last_byte) begin
          valid_q <= 1'b0;
          idx_q   <= '0;
        end else begin
          idx_q <= idx_q + 4'd1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (idx_q < cur_q.count))
    else $error("byte index past end of run");
`endif

endmodule

/* src/zlib_stored_block_encoder.sv */
`timescale 1ns / 1ps

// zlib stream encoder using stored deflate blocks only, with Adler-32 trailer.
// Configuration: write cfg_wdata_i with cfg_we_i high to set the stream length
//   in bytes; it is sampled by the next start item.
// Input channel (s_axis_*): tuser = 0 starts a stream (emits 78 01, plus the
//   trailer 00 00 00 01 for an empty stream), tuser = 1 carries one data byte in
//   tdata. Data bytes with no stream open are taken and dropped.
// Output channel (m_axis_*): one zlib byte per item; tlast marks the final byte
//   caused by one input item, tuser marks the last byte of the whole stream.
// Each accepted start or in-stream data item updates the counters and Adler sums in
//   the same cycle and queues a run of 1 to 10 bytes; a serializer replays each run
//   one byte a cycle while tready is high, from a register loaded out of the run queue.
// Throughput: one input item per cycle while each yields one byte (bytes inside
//   a block) and tready stays high; a block start adds 5 header bytes, stream end 4.
//   The output port, which moves one byte per cycle while tready is high, sets the rate.
// Stall: when the receiver holds tready low, output bytes hold; the two-entry run
//   queue fills and s_axis_tready drops until a run is fully sent.
// Reset: asynchronous, clears the queue, counters and stream length; Adler starts at 1.
module zlib_stored_block_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // [0] stream_done
);
  import zsbe_pkg::*;

  logic accept;
  logic push;
  logic load;
  logic q_full;
  logic q_empty;
  run_t run_new;
  run_t run_head;

  // Ready comes straight from the queue fill register
  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  zsbe_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .mode_i      (s_axis_tuser),
    .data_byte_i (s_axis_tdata),
    .push_o      (push),
    .run_o       (run_new)
  );

  zsbe_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .run_i   (run_new),
    .pop_i   (load),
    .full_o  (q_full),
    .empty_o (q_empty),
    .run_o   (run_head)
  );

  zsbe_ser u_ser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (!q_empty),
    .run_i   (run_head),
    .load_o  (load),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .byte_o  (m_axis_tdata),
    .last_o  (m_axis_tlast),
    .done_o  (m_axis_tuser)
  );

`ifndef SYNTHESIS
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("stream end not on last byte of a run");
`endif

endmodule

/* dv/zlib_stored_block_encoder_tb.sv */
`timescale 1ns / 1ps

module zlib_stored_block_encoder_tb;

  import zsbe_pkg::MODE_START;
  import zsbe_pkg::MODE_DATA;

  // zlib and stored-block framing values, kept separate from the design package
  localparam logic [7:0]  ZHDR_CMF   = 8'h78;
  localparam logic [7:0]  ZHDR_FLG   = 8'h01;
  localparam logic [7:0]  BLK_LAST   = 8'h01;
  localparam logic [7:0]  BLK_MORE   = 8'h00;
  localparam logic [31:0] BLOCK_MAX  = 32'd65535;
  localparam logic [16:0] ADLER_BASE = 17'd65521;

  localparam int RAND_ITEMS   = 130;
  localparam int LONG_STREAM  = 300;     // enough mostly-0xFF bytes to wrap both Adler sums
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 4;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int PRINT_CAP    = 40;

  typedef struct {
    logic [7:0] value;
    logic       last;
    logic       done;
  } zbyte_t;

  // Tracks the encoder state and holds the zlib bytes still owed by the block
  class zlib_stream_scoreboard;
    logic [31:0] length_reg;
    logic [31:0] left_total;
    logic [15:0] left_block;
    logic [15:0] sum_a;
    logic [15:0] sum_b;
    zbyte_t      run_q[$];
    zbyte_t      pending[$];
    int          n_errors, n_checked, n_inputs, n_ignored, n_streams, n_blocks;

    function new();
      length_reg = '0;
      left_total = '0;
      left_block = '0;
      sum_a      = 16'd1;
      sum_b      = 16'd0;
    endfunction

    function void write_length(logic [31:0] v);
      length_reg = v;
    endfunction

    function void emit(logic [7:0] v, logic d = 1'b0);
      zbyte_t z;
      z.value = v;
      z.last  = 1'b0;
      z.done  = d;
      run_q.insert(run_q.size(), z);
    endfunction

    // Adler-32 goes out most significant byte first and closes the stream
    function void emit_adler();
      emit(sum_b[15:8]);
      emit(sum_b[7:0]);
      emit(sum_a[15:8]);
      emit(sum_a[7:0], 1'b1);
    endfunction

    function void note_input(logic mode, logic [7:0] data);
      logic [15:0] blk_len;
      logic [16:0] acc;
      zbyte_t      z;
      run_q.delete();
      n_inputs++;
      if (mode == MODE_START) begin
        // load counters from the register; abandon any open stream
        left_total = length_reg;
        left_block = '0;
        sum_a      = 16'd1;
        sum_b      = 16'd0;
        n_streams++;
        emit(ZHDR_CMF);
        emit(ZHDR_FLG);
        if (left_total == 0) emit_adler();
      end else if (left_total == 0) begin
        // no stream open: the byte is dropped
        n_ignored++;
      end else begin
        if (left_block == 0) begin
          blk_len = (left_total < BLOCK_MAX) ? left_total[15:0] : BLOCK_MAX[15:0];
          emit((left_total <= BLOCK_MAX) ? BLK_LAST : BLK_MORE);
          emit(blk_len[7:0]);
          emit(blk_len[15:8]);
          emit(~blk_len[7:0]);
          emit(~blk_len[15:8]);
          left_block = blk_len;
          n_blocks++;
        end
        emit(data);
        acc = 17'(sum_a) + 17'(data);
        if (acc >= ADLER_BASE) acc = acc - ADLER_BASE;
        sum_a = acc[15:0];
        acc = 17'(sum_b) + 17'(sum_a);
        if (acc >= ADLER_BASE) acc = acc - ADLER_BASE;
        sum_b = acc[15:0];
        left_block = left_block - 16'd1;
        left_total = left_total - 32'd1;
        if (left_total == 0) begin
          left_block = '0;
          emit_adler();
        end
      end
      // mark the final byte of this item's run and queue the run
      for (int i = 0; i < run_q.size(); i++) begin
        z      = run_q[i];
        z.last = (i == run_q.size() - 1);
        pending.insert(pending.size(), z);
      end
    endfunction

    task report(string msg);
      n_errors++;
      if (n_errors <= PRINT_CAP)
        $display("[%0t] mismatch at output byte %0d: %s", $time, n_checked, msg);
    endtask

    task check_result(logic [7:0] b, logic last, logic done);
      zbyte_t want;
      n_checked++;
      if (pending.size() == 0) begin
        report($sformatf("byte %02h arrived with nothing pending", b));
        return;
      end
      want = pending.pop_front();
      if (b !== want.value)
        report($sformatf("out_byte %02h, want %02h", b, want.value));
      if (last !== want.last)
        report($sformatf("last_of_run %b, want %b", last, want.last));
      if (done !== want.done)
        report($sformatf("stream_done %b, want %b", done, want.done));
    endtask
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [31:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] data_byte
  logic        s_axis_tuser  = 1'b0; // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // [7:0] out_byte
  logic        m_axis_tlast;
  logic        m_axis_tuser;         // [0] stream_done

  zlib_stream_scoreboard sb;

  int cycle_count = 0;
  int burst_left  = 0;
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;
  int stretch_left = 0;
  int ready_pct = 100;

  zlib_stored_block_encoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still pending", cycle_count,
               sb.pending.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: stretches of random ready density, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (holds_asked != holds_served) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(5, 60);
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 80;
          2: ready_pct = 50;
          default: ready_pct = 20;
        endcase
      end
      stretch_left--;
      m_axis_tready <= ($urandom_range(1, 100) <= ready_pct);
    end
  end

  // Check every byte taken from the output
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  // Offer one item in bursts with random gaps; return once it is taken
  task automatic send_item(input logic mode, input logic [7:0] data);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(mode, data);
  endtask

  // Drop valid, let every owed byte drain, then give dropped bytes time to clear
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [31:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.write_length(v);
  endtask

  initial begin
    logic [31:0] len;
    int          n_send, rand_count, pick;
    bit          heavy, huge, held;

    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // data byte before any stream: dropped
    send_item(MODE_DATA, 8'hFF);

    // zero-length stream: header plus Adler of nothing, then a stray byte
    wait_idle();
    write_length(32'd0);
    send_item(MODE_START, 8'h00);
    send_item(MODE_DATA, 8'h00);

    // short single-block stream with the byte extremes
    wait_idle();
    write_length(32'd3);
    send_item(MODE_START, 8'hFF);
    send_item(MODE_DATA, 8'h00);
    send_item(MODE_DATA, 8'hFF);
    send_item(MODE_DATA, 8'hA5);

    // maximum length: non-final full block; rewrite the length mid-stream,
    // which must only take effect at the next start
    wait_idle();
    write_length(32'hFFFF_FFFF);
    send_item(MODE_START, 8'h00);
    send_item(MODE_DATA, 8'hFF);
    send_item(MODE_DATA, 8'h80);
    wait_idle();
    write_length(32'd2);
    send_item(MODE_DATA, 8'h7F);
    send_item(MODE_START, 8'h00);
    send_item(MODE_DATA, 8'h01);
    send_item(MODE_DATA, 8'hFE);

    // exactly one full final block, restarted before it ends
    wait_idle();
    write_length(BLOCK_MAX);
    send_item(MODE_START, 8'h00);
    send_item(MODE_DATA, 8'h55);
    send_item(MODE_DATA, 8'hAA);
    send_item(MODE_START, 8'h00);
    send_item(MODE_DATA, 8'h0F);

    // long stream under a receiver hold-off: wraps both Adler sums
    wait_idle();
    write_length(LONG_STREAM);
    send_item(MODE_START, 8'h00);
    holds_asked++;
    for (int i = 0; i < LONG_STREAM; i++)
      send_item(MODE_DATA, ($urandom_range(0, 7) != 0) ? 8'hFF : 8'($urandom));

    // random phases: mostly complete streams, some cut short, some with stray bytes
    rand_count = 0;
    held = 1'b0;
    while (rand_count < RAND_ITEMS) begin
      pick  = $urandom_range(0, 19);
      heavy = 1'b0;
      huge  = 1'b0;
      if (pick == 0) begin
        len = 32'd0;
      end else if (pick == 1) begin
        len   = $urandom_range(20, 60);
        heavy = 1'b1;
      end else if (pick == 2) begin
        len  = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : $urandom;
        huge = (len > 32'd1000);
      end else begin
        len = $urandom_range(1, 24);
      end

      wait_idle();
      write_length(len);
      if (!held && rand_count > 40) begin
        holds_asked++;
        held = 1'b1;
      end
      send_item(MODE_START, 8'($urandom));

      if (huge)
        n_send = $urandom_range(1, 12);
      else if (len != 0 && $urandom_range(0, 5) == 0)
        n_send = $urandom_range(0, int'(len) - 1);
      else
        n_send = int'(len);
      for (int i = 0; i < n_send; i++)
        send_item(MODE_DATA, (heavy && $urandom_range(0, 7) != 0) ? 8'hFF : 8'($urandom));
      rand_count += 1 + n_send;

      // stray bytes after a closed stream are dropped by the block
      if (n_send == int'(len) && $urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3)) send_item(MODE_DATA, 8'($urandom));
    end

    wait_idle();
    repeat (20) @(posedge clk_i);

    $display("covered %0d streams and %0d stored blocks from %0d input items",
             sb.n_streams, sb.n_blocks, sb.n_inputs);
    $display("%0d stray bytes dropped, %0d output bytes checked, %0d mismatches",
             sb.n_ignored, sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
src/zsbe_pkg.sv
src/zsbe_core.sv
src/zsbe_fifo.sv
src/zsbe_ser.sv
src/zlib_stored_block_encoder.sv
dv/zlib_stored_block_encoder_tb.sv
